// ===== rtl/core/cfb_pkg.sv =====
// shared types and constants for the clipped framebuffer blit
package cfb_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int OFFSET_BITS = 24;

  localparam int DIM_W       = 13;
  localparam int COORD_W     = 16;
  localparam int PIXEL_W     = 32;
  localparam int FB_OFFSET_W = 24;
  localparam int FB_BYTE_W   = 8;
  localparam int CFG_INDEX_W = 1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0] DISP_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] DISP_HEIGHT_RESET = 13'd480;

  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic OUT_WRITE = 1'b0;
  localparam logic OUT_SYNC  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_DISP_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISP_HEIGHT = 1'b1;

  localparam logic [FB_BYTE_W-1:0] SYNC_BYTE = 8'd1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
    logic               wide_mode;
    logic               want_sync;
    logic [PIXEL_W-1:0] pixel_value;
  } item_t;

  typedef struct packed {
    logic                   out_kind;
    logic [FB_OFFSET_W-1:0] fb_offset;
    logic [FB_BYTE_W-1:0]   fb_byte;
    logic                   last;
  } result_t;

  function automatic logic [FB_BYTE_W-1:0] pack332(input logic [PIXEL_W-1:0] p);
    pack332 = {p[23:21], p[15:13], p[7:6]};
  endfunction

endpackage

// ===== rtl/core/cfb_item_if.sv =====
// input word channel of the blit
interface cfb_item_if;
  logic           valid;
  logic           ready;
  cfb_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cfb_result_if.sv =====
// result word channel of the blit
interface cfb_result_if;
  logic             valid;
  logic             ready;
  cfb_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/clipped_framebuffer_blit.sv =====
// clipped framebuffer blit: begin/pixel words in, byte writes and sync words out
//
//   channel  dir  word                                   accepted when
//   item     in   begin or pixel                         item.valid && item.ready
//   result   out  byte write or sync                     result.valid && result.ready
//   cfg      in   display width / height write           cfg_we
//
// one word per cycle: a word is decoded, clipped and addressed in the cycle it is taken,
// its results land in a four-entry output queue and are offered from the next cycle
// begin words do one 13x16 multiply; a pixel inside the clip that closes a synced rectangle adds two
// item.ready is high while at most two results wait, so a stalled result side
// stops input once three or more results are queued
// synchronous reset clears command state, counters and the queue; registers go to 640x480
module clipped_framebuffer_blit #(
  parameter int MAX_DIM     = cfb_pkg::MAX_DIM,
  parameter int OFFSET_BITS = cfb_pkg::OFFSET_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  cfb_item_if.sink                            item,
  cfb_result_if.source                        result,
  input  logic                                cfg_we,
  input  logic [cfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cfb_pkg::DIM_W-1:0]           cfg_data
);

  localparam int DimW   = cfb_pkg::DIM_W;
  localparam int CoordW = cfb_pkg::COORD_W;
  localparam int ProdW  = DimW + CoordW;
  localparam int Depth  = cfb_pkg::QUEUE_DEPTH;
  localparam int PtrW   = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam logic [DimW-1:0] MaxDim =
    (MAX_DIM >= (1 << DimW)) ? {DimW{1'b1}} : DimW'(MAX_DIM);

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    clamp_dim = (v > MaxDim) ? MaxDim : v;
  endfunction

  // configuration
  logic [DimW-1:0] disp_width;
  logic [DimW-1:0] disp_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_width  <= cfb_pkg::DISP_WIDTH_RESET;
      disp_height <= cfb_pkg::DISP_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cfb_pkg::REG_DISP_WIDTH:  disp_width  <= clamp_dim(cfg_data);
        cfb_pkg::REG_DISP_HEIGHT: disp_height <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // command state
  logic [CoordW-1:0]      origin_x;
  logic [DimW-1:0]        src_width;
  logic [DimW-1:0]        src_height;
  logic [DimW-1:0]        clip_width;
  logic [DimW-1:0]        clip_height;
  logic [DimW-1:0]        col_count;
  logic [DimW-1:0]        row_count;
  logic [OFFSET_BITS-1:0] row_base;
  logic                   active;
  logic                   wide;
  logic                   sync;

  // output queue
  cfb_pkg::result_t q [Depth];
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] tail;
  logic [CntW-1:0] count;

  logic take;
  logic pop;
  assign item.ready   = (count <= CntW'(Depth - 2));
  assign take         = item.valid && item.ready;
  assign result.valid = (count != '0);
  assign result.data  = q[head];
  assign pop          = result.valid && result.ready;

  // begin decode
  logic [DimW-1:0]   w;
  logic [DimW-1:0]   h;
  logic              rejected;
  logic [DimW-1:0]   room_w;
  logic [DimW-1:0]   room_h;
  logic [ProdW-1:0]  prod;
  logic              empty_src;

  assign w         = clamp_dim(item.data.rect_w);
  assign h         = clamp_dim(item.data.rect_h);
  assign rejected  = (item.data.rect_x > CoordW'(disp_width)) ||
                     (item.data.rect_y > CoordW'(disp_height));
  assign room_w    = disp_width - DimW'(item.data.rect_x);
  assign room_h    = disp_height - DimW'(item.data.rect_y);
  assign prod      = ProdW'(disp_width) * ProdW'(item.data.rect_y);
  assign empty_src = (w == '0) || (h == '0);

  // pixel decode
  logic                   end_row;
  logic                   end_all;
  logic                   do_sync;
  logic                   in_clip;
  logic [OFFSET_BITS-1:0] off;
  logic [cfb_pkg::FB_BYTE_W-1:0] pix_byte;

  assign end_row  = ({1'b0, col_count} + (DimW+1)'(1)) >= {1'b0, src_width};
  assign end_all  = end_row &&
                    (({1'b0, row_count} + (DimW+1)'(1)) >= {1'b0, src_height});
  assign do_sync  = end_all && sync;
  assign in_clip  = (col_count < clip_width) && (row_count < clip_height);
  assign off      = row_base + OFFSET_BITS'(origin_x) + OFFSET_BITS'(col_count);
  assign pix_byte = wide ? cfb_pkg::pack332(item.data.pixel_value)
                         : item.data.pixel_value[cfb_pkg::FB_BYTE_W-1:0];

  cfb_pkg::result_t sync_word;
  cfb_pkg::result_t write_word;
  assign sync_word  = '{out_kind: cfb_pkg::OUT_SYNC, fb_offset: '0,
                        fb_byte: cfb_pkg::SYNC_BYTE, last: 1'b1};
  assign write_word = '{out_kind: cfb_pkg::OUT_WRITE,
                        fb_offset: cfb_pkg::FB_OFFSET_W'(off),
                        fb_byte: pix_byte, last: !do_sync};

  logic             first_v;
  logic             second_v;
  cfb_pkg::result_t first;

  always_comb begin
    first_v  = 1'b0;
    second_v = 1'b0;
    first    = sync_word;
    if (take) begin
      if (item.data.kind == cfb_pkg::KIND_BEGIN) begin
        first_v = empty_src && item.data.want_sync && !rejected;
      end else if (active) begin
        if (in_clip) begin
          first_v  = 1'b1;
          first    = write_word;
          second_v = do_sync;
        end else begin
          first_v = do_sync;
        end
      end
    end
  end

  logic [CntW-1:0] push_n;
  assign push_n = CntW'(first_v) + CntW'(second_v);

  always_ff @(posedge clk) begin
    if (first_v) begin
      q[tail] <= first;
    end
    if (second_v) begin
      q[tail + PtrW'(1)] <= sync_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PtrW'(pop);
      tail  <= tail + PtrW'(push_n);
      count <= count + push_n - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      src_width   <= '0;
      src_height  <= '0;
      clip_width  <= '0;
      clip_height <= '0;
      col_count   <= '0;
      row_count   <= '0;
      row_base    <= '0;
      active      <= 1'b0;
      wide        <= 1'b0;
      sync        <= 1'b0;
    end else if (take) begin
      if (item.data.kind == cfb_pkg::KIND_BEGIN) begin
        origin_x    <= item.data.rect_x;
        src_width   <= w;
        src_height  <= h;
        col_count   <= '0;
        row_count   <= '0;
        row_base    <= OFFSET_BITS'(prod);
        clip_width  <= rejected ? '0 : ((w < room_w) ? w : room_w);
        clip_height <= rejected ? '0 : ((h < room_h) ? h : room_h);
        active      <= !empty_src;
        wide        <= !empty_src && item.data.wide_mode;
        sync        <= !empty_src && item.data.want_sync && !rejected;
      end else if (active) begin
        if (end_all) begin
          active    <= 1'b0;
          wide      <= 1'b0;
          sync      <= 1'b0;
          col_count <= '0;
          row_count <= '0;
        end else if (end_row) begin
          col_count <= '0;
          row_count <= row_count + DimW'(1);
          row_base  <= row_base + OFFSET_BITS'(disp_width);
        end else begin
          col_count <= col_count + DimW'(1);
        end
      end
    end
  end

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result queue overflow");

  a_active_dims: assert property (@(posedge clk) disable iff (rst)
    active |-> (src_width != '0) && (src_height != '0))
    else $error("active command with empty source");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (col_count < src_width) && (row_count < src_height))
    else $error("position counter beyond source size");

  a_clip_in_source: assert property (@(posedge clk) disable iff (rst)
    (clip_width <= src_width) && (clip_height <= src_height))
    else $error("clip area larger than source");

endmodule

// ===== sim/clipped_framebuffer_blit_tb.sv =====
// testbench for the clipped framebuffer blit: directed cases and random rectangles against a cycle-free predictor
`timescale 1ns / 1ps

module clipped_framebuffer_blit_tb;

  localparam int LIMIT = 500000;
  localparam int PHASE_ITEMS = 150;
  localparam int TAIL_START = 900;
  localparam int PHASE_W[7] = '{640, 4096, 17, 1, 8191, 3, 0};
  localparam int PHASE_H[7] = '{480, 4096, 9, 1, 2, 8191, 0};

  class blit_scoreboard;
    cfb_pkg::result_t                expected_q[$];
    int unsigned                     mismatches;
    int unsigned                     writes_seen;
    int unsigned                     syncs_seen;
    logic [cfb_pkg::DIM_W-1:0]       scr_w;
    logic [cfb_pkg::DIM_W-1:0]       scr_h;
    logic [cfb_pkg::COORD_W-1:0]     org_x;
    logic [cfb_pkg::DIM_W-1:0]       src_w;
    logic [cfb_pkg::DIM_W-1:0]       src_h;
    logic [cfb_pkg::DIM_W-1:0]       clip_w;
    logic [cfb_pkg::DIM_W-1:0]       clip_h;
    logic [cfb_pkg::DIM_W-1:0]       col_cnt;
    logic [cfb_pkg::DIM_W-1:0]       row_cnt;
    logic [cfb_pkg::FB_OFFSET_W-1:0] row_base;
    logic                            cmd_active;
    logic                            cmd_wide;
    logic                            cmd_sync;

    function new();
      scr_w = cfb_pkg::DISP_WIDTH_RESET;
      scr_h = cfb_pkg::DISP_HEIGHT_RESET;
      org_x = '0;
      src_w = '0;
      src_h = '0;
      clip_w = '0;
      clip_h = '0;
      col_cnt = '0;
      row_cnt = '0;
      row_base = '0;
      cmd_active = 1'b0;
      cmd_wide = 1'b0;
      cmd_sync = 1'b0;
      mismatches = 0;
      writes_seen = 0;
      syncs_seen = 0;
    endfunction

    function logic [cfb_pkg::DIM_W-1:0] clamp_dim(input logic [cfb_pkg::DIM_W-1:0] v);
      return (v > cfb_pkg::DIM_W'(cfb_pkg::MAX_DIM)) ? cfb_pkg::DIM_W'(cfb_pkg::MAX_DIM) : v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(input logic [cfb_pkg::CFG_INDEX_W-1:0] idx,
                          input logic [cfb_pkg::DIM_W-1:0] v);
      if (idx == cfb_pkg::REG_DISP_WIDTH) scr_w = clamp_dim(v);
      else scr_h = clamp_dim(v);
    endfunction

    function void push_result(input logic kind, input logic [cfb_pkg::FB_OFFSET_W-1:0] off,
                              input logic [cfb_pkg::FB_BYTE_W-1:0] color, input logic fin);
      cfb_pkg::result_t r;
      r.out_kind = kind;
      r.fb_offset = off;
      r.fb_byte = color;
      r.last = fin;
      expected_q.push_back(r);
    endfunction

    function void note_item(input cfb_pkg::item_t w);
      logic [cfb_pkg::DIM_W-1:0]     cw;
      logic [cfb_pkg::DIM_W-1:0]     ch;
      logic [cfb_pkg::DIM_W-1:0]     room;
      logic                          rejected;
      logic                          end_row;
      logic                          end_all;
      logic                          do_sync;
      logic [cfb_pkg::FB_BYTE_W-1:0] color;
      logic [31:0]                   prod;
      if (w.kind == cfb_pkg::KIND_BEGIN) begin
        cw = clamp_dim(w.rect_w);
        ch = clamp_dim(w.rect_h);
        rejected = (w.rect_x > cfb_pkg::COORD_W'(scr_w)) ||
                   (w.rect_y > cfb_pkg::COORD_W'(scr_h));
        org_x = w.rect_x;
        src_w = cw;
        src_h = ch;
        col_cnt = '0;
        row_cnt = '0;
        prod = 32'(scr_w) * 32'(w.rect_y);
        row_base = prod[cfb_pkg::FB_OFFSET_W-1:0];
        if (rejected) begin
          clip_w = '0;
          clip_h = '0;
        end else begin
          room = scr_w - w.rect_x[cfb_pkg::DIM_W-1:0];
          clip_w = (cw < room) ? cw : room;
          room = scr_h - w.rect_y[cfb_pkg::DIM_W-1:0];
          clip_h = (ch < room) ? ch : room;
        end
        cmd_active = (cw != '0) && (ch != '0);
        cmd_wide = w.wide_mode;
        cmd_sync = w.want_sync && !rejected;
        // empty rectangle: sync goes out on the begin word itself
        if (!cmd_active && cmd_sync)
          push_result(cfb_pkg::OUT_SYNC, '0, cfb_pkg::SYNC_BYTE, 1'b1);
      end else if (cmd_active) begin
        end_row = (int'(col_cnt) + 1) >= int'(src_w);
        end_all = end_row && ((int'(row_cnt) + 1) >= int'(src_h));
        do_sync = end_all && cmd_sync;
        if (col_cnt < clip_w && row_cnt < clip_h) begin
          // rgb888 to rgb332: top bits of red, green, blue
          color = cmd_wide ? {w.pixel_value[23:21], w.pixel_value[15:13], w.pixel_value[7:6]}
                           : w.pixel_value[7:0];
          push_result(cfb_pkg::OUT_WRITE,
                      row_base + cfb_pkg::FB_OFFSET_W'(org_x) + cfb_pkg::FB_OFFSET_W'(col_cnt),
                      color, !do_sync);
        end
        if (do_sync) push_result(cfb_pkg::OUT_SYNC, '0, cfb_pkg::SYNC_BYTE, 1'b1);
        if (end_all) begin
          cmd_active = 1'b0;
          col_cnt = '0;
          row_cnt = '0;
        end else if (end_row) begin
          col_cnt = '0;
          row_cnt = row_cnt + cfb_pkg::DIM_W'(1);
          row_base = row_base + cfb_pkg::FB_OFFSET_W'(scr_w);
        end else begin
          col_cnt = col_cnt + cfb_pkg::DIM_W'(1);
        end
      end
    endfunction

    function void report(input string what, input cfb_pkg::result_t e,
                         input cfb_pkg::result_t r);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s): expected kind %0d offset 0x%06h byte 0x%02h last %0d",
                 what, e.out_kind, e.fb_offset, e.fb_byte, e.last);
        $display("  got kind %0d offset 0x%06h byte 0x%02h last %0d",
                 r.out_kind, r.fb_offset, r.fb_byte, r.last);
      end
    endfunction

    function void check_result(input cfb_pkg::result_t r);
      cfb_pkg::result_t e;
      if (r.out_kind == cfb_pkg::OUT_SYNC) syncs_seen++;
      else writes_seen++;
      if (expected_q.size() == 0) begin
        e = '0;
        report("no result pending", e, r);
      end else begin
        e = expected_q.pop_front();
        if (r.out_kind !== e.out_kind || r.fb_offset !== e.fb_offset ||
            r.fb_byte !== e.fb_byte || r.last !== e.last)
          report("field differs", e, r);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cfb_pkg::DIM_W-1:0]       cfg_data;

  cfb_item_if   item_if ();
  cfb_result_if res_if ();

  clipped_framebuffer_blit dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blit_scoreboard sb;
  int             items_sent = 0;
  int             sizes_used = 1;
  int             hold_cycles = 0;
  int             cycles = 0;
  bit             gaps_on = 1'b0;
  bit             stalls_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready) sb.note_item(item_if.data);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input cfb_pkg::item_t w, input bit counted);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data <= w;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  task automatic send_begin(input logic [cfb_pkg::COORD_W-1:0] x, y,
                            input logic [cfb_pkg::DIM_W-1:0] w, h,
                            input logic wide, sync);
    cfb_pkg::item_t it;
    it.kind = cfb_pkg::KIND_BEGIN;
    it.rect_x = x;
    it.rect_y = y;
    it.rect_w = w;
    it.rect_h = h;
    it.wide_mode = wide;
    it.want_sync = sync;
    it.pixel_value = $urandom;
    send_word(it, 1'b1);
  endtask

  task automatic send_pixel(input logic [cfb_pkg::PIXEL_W-1:0] value, input bit counted);
    cfb_pkg::item_t it;
    it.kind = cfb_pkg::KIND_PIXEL;
    it.rect_x = cfb_pkg::COORD_W'($urandom);
    it.rect_y = cfb_pkg::COORD_W'($urandom);
    it.rect_w = cfb_pkg::DIM_W'($urandom);
    it.rect_h = cfb_pkg::DIM_W'($urandom);
    it.wide_mode = 1'($urandom);
    it.want_sync = 1'($urandom);
    it.pixel_value = value;
    send_word(it, counted);
  endtask

  task automatic send_rect(input logic [cfb_pkg::COORD_W-1:0] x, y,
                           input logic [cfb_pkg::DIM_W-1:0] w, h,
                           input logic wide, sync, input int npix);
    send_begin(x, y, w, h, wide, sync);
    repeat (npix) send_pixel($urandom, 1'b1);
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cfb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cfb_pkg::DIM_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [cfb_pkg::COORD_W-1:0] pick_coord(
      input logic [cfb_pkg::DIM_W-1:0] lim);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, int'(lim) - 1));
      6, 7: v = int'(lim) - int'($urandom_range(1, 3));
      8: v = int'(lim) + int'($urandom_range(0, 1));
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    return cfb_pkg::COORD_W'(v);
  endfunction

  function automatic logic [cfb_pkg::DIM_W-1:0] pick_dim();
    int r;
    r = int'($urandom_range(0, 19));
    if (r <= 16) return cfb_pkg::DIM_W'($urandom_range(0, 6));
    if (r == 17) return cfb_pkg::DIM_W'($urandom_range(7, 16));
    if (r == 18) return cfb_pkg::DIM_W'(cfb_pkg::MAX_DIM);
    return cfb_pkg::DIM_W'($urandom_range(0, 8191));
  endfunction

  task automatic random_rect();
    logic [cfb_pkg::COORD_W-1:0] x;
    logic [cfb_pkg::COORD_W-1:0] y;
    logic [cfb_pkg::DIM_W-1:0]   w;
    logic [cfb_pkg::DIM_W-1:0]   h;
    int                          total;
    int                          npix;
    x = pick_coord(sb.scr_w);
    y = pick_coord(sb.scr_h);
    w = pick_dim();
    h = pick_dim();
    total = int'(w) * int'(h);
    // oversize or cut short: the next begin abandons the command
    if (total > 64) npix = $urandom_range(0, 20);
    else if (total > 0 && $urandom_range(0, 9) == 0) npix = $urandom_range(0, total - 1);
    else npix = total;
    send_rect(x, y, w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), npix);
    if (npix == total && $urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 2)) send_pixel($urandom, 1'b0);
  endtask

  task automatic directed_checks();
    // pixel with nothing active
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_rect(16'd0, 16'd0, 13'd2, 13'd1, 1'b1, 1'b1, 0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b1);
    // empty source with sync
    send_begin(16'd5, 16'd5, 13'd0, 13'd5, 1'b0, 1'b1);
    // rejected origins
    send_rect(16'd641, 16'd0, 13'd1, 13'd2, 1'b1, 1'b1, 2);
    send_rect(16'd0, 16'd481, 13'd1, 13'd1, 1'b0, 1'b1, 1);
    // origin on the screen edge
    send_rect(16'd640, 16'd480, 13'd1, 13'd1, 1'b0, 1'b1, 1);
    // oversize source, then abandoned by a new begin
    send_begin(16'd639, 16'd479, 13'd8191, 13'd8191, 1'b0, 1'b0);
    send_pixel(32'h1234_56AB, 1'b1);
    send_rect(16'hFFFF, 16'hFFFF, 13'd1, 13'd1, 1'b1, 1'b1, 1);
    // partial clip at the right edge
    send_rect(16'd638, 16'd0, 13'd3, 13'd2, 1'b0, 1'b0, 6);
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= cfb_pkg::REG_DISP_WIDTH;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed_checks();
    settle();

    // long result hold-off while a full rectangle is offered
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_cycles = 300;
    send_rect(16'd0, 16'd0, 13'd8, 13'd5, 1'($urandom_range(0, 1)), 1'b1, 40);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        settle();
        if (p == 2) begin
          // stride change between rows of an open command
          send_rect(16'd0, 16'd0, 13'd3, 13'd3, 1'b0, 1'b1, 3);
          settle();
          write_reg(cfb_pkg::REG_DISP_WIDTH, cfb_pkg::DIM_W'(PHASE_W[p]));
          write_reg(cfb_pkg::REG_DISP_HEIGHT, cfb_pkg::DIM_W'(PHASE_H[p]));
          repeat (6) send_pixel($urandom, 1'b1);
        end else if (p == 6) begin
          write_reg(cfb_pkg::REG_DISP_WIDTH, cfb_pkg::DIM_W'($urandom_range(1, 8191)));
          write_reg(cfb_pkg::REG_DISP_HEIGHT, cfb_pkg::DIM_W'($urandom_range(1, 8191)));
        end else begin
          write_reg(cfb_pkg::REG_DISP_WIDTH, cfb_pkg::DIM_W'(PHASE_W[p]));
          write_reg(cfb_pkg::REG_DISP_HEIGHT, cfb_pkg::DIM_W'(PHASE_H[p]));
        end
        sizes_used++;
      end
      gaps_on = (p != 3);
      stalls_on = (p != 3);
      while (items_sent < (p + 1) * PHASE_ITEMS) begin
        if (items_sent >= TAIL_START) begin
          gaps_on = 1'b0;
          stalls_on = 1'b0;
        end
        random_rect();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("run covered %0d input words over %0d screen sizes", items_sent, sizes_used);
    $display("checked %0d byte writes and %0d sync words, %0d mismatches, %0d left over",
             sb.writes_seen, sb.syncs_seen, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
